// ===== rtl/tnds_pkg.sv =====
// Shared types and constants for the top-N dot-product search block.
`default_nettype none
package tnds_pkg;

   localparam int TOP_N   = 40;
   localparam int MAX_DIM = 256;
   localparam int ID_BITS = 20;

   localparam int VAL_W   = 16;
   localparam int IDX_W   = 8;
   localparam int RANK_W  = 6;
   localparam int LEN_W   = 9;
   localparam int MIN_W   = 15;
   localparam int PROD_W  = 32;
   localparam int ACC_W   = 40;
   localparam int SCORE_W = 32;
   localparam int CSR_W   = 15;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_CAND  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic {
      CSR_MIN_SCORE     = 1'b0,
      CSR_VECTOR_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type                action;
      logic signed [VAL_W-1:0]   element_value;
      logic [IDX_W-1:0]          element_index;
      logic [ID_BITS-1:0]        candidate_id;
      logic                      exclude;
      logic [RANK_W-1:0]         rank;
   } req_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [ID_BITS-1:0]        word_id;
      logic                      valid_res;
   } rsp_type;

   // Item leaving the dot-product pipeline toward the result list.
   typedef struct packed {
      logic                      valid;
      action_type                action;
      logic                      last;
      logic signed [SCORE_W-1:0] score;
      logic [ID_BITS-1:0]        id;
      logic                      excl;
      logic [RANK_W-1:0]         rank;
   } stage_type;

endpackage
`default_nettype wire

// ===== rtl/tnds_cell.sv =====
// One slot of the sorted result list, shifting toward higher ranks on insert.
`default_nettype none
module tnds_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               clear,
   input  wire logic                               insert,
   input  wire logic signed [tnds_pkg::SCORE_W-1:0] new_score,
   input  wire logic [tnds_pkg::ID_BITS-1:0]       new_id,
   input  wire logic signed [tnds_pkg::SCORE_W-1:0] prev_score,
   input  wire logic [tnds_pkg::ID_BITS-1:0]       prev_id,
   input  wire logic                               prev_gt,
   output logic signed [tnds_pkg::SCORE_W-1:0]     score,
   output logic [tnds_pkg::ID_BITS-1:0]            id,
   output logic                                    gt
);
   import tnds_pkg::*;

   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [ID_BITS-1:0]        id_ff, id_in;

   // The list stays sorted, so gt is true from the insert position onward.
   assign gt = new_score > score_ff;

   always_comb begin
      score_in = score_ff;
      id_in    = id_ff;
      if (clear) begin
         score_in = '0;
         id_in    = '0;
      end else if (insert && gt) begin
         if (prev_gt) begin
            score_in = prev_score;
            id_in    = prev_id;
         end else begin
            score_in = new_score;
            id_in    = new_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff <= '0;
         id_ff    <= '0;
      end else if (en) begin
         score_ff <= score_in;
         id_ff    <= id_in;
      end
   end

   assign score = score_ff;
   assign id    = id_ff;

endmodule
`default_nettype wire

// ===== rtl/tnds_dot.sv =====
// Query memory, multiplier and saturating accumulator pipeline.
`default_nettype none
module tnds_dot (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         accept,
   input  wire tnds_pkg::req_type            req,
   input  wire logic [tnds_pkg::LEN_W-1:0]   eff_len,
   output tnds_pkg::stage_type               stage
);
   import tnds_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DIM);

   logic signed [VAL_W-1:0] query_mem [MAX_DIM];

   logic [LEN_W-1:0]        count_ff, count_in;
   logic [LEN_W:0]          count_next;
   logic                    last;

   logic                    s1_valid_ff, s1_last_ff, s1_qok_ff;
   req_type                 s1_req_ff;
   logic signed [VAL_W-1:0] q_rd_ff;
   logic signed [VAL_W-1:0] q_use;

   logic                    s2_valid_ff, s2_last_ff;
   req_type                 s2_req_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W:0]   sum;
   logic signed [ACC_W-1:0] acc_sat;
   logic signed [SCORE_W-1:0] score_sat;
   stage_type               s3_ff, s3_in;

   // Stage 1: query write, query read at the element position, position count.
   assign count_next = {1'b0, count_ff} + (LEN_W+1)'(1);
   assign last       = count_next >= {1'b0, eff_len};

   always_comb begin
      count_in = count_ff;
      if (accept && req.action == ACT_CAND) begin
         count_in = last ? '0 : count_next[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.action == ACT_LOAD
          && {1'b0, req.element_index} < (IDX_W+1)'(MAX_DIM)) begin
         query_mem[req.element_index[ADDR_W-1:0]] <= req.element_value;
      end
      if (en) begin
         q_rd_ff <= query_mem[count_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         count_ff    <= count_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_req_ff  <= req;
         s1_last_ff <= last;
         s1_qok_ff  <= count_ff < LEN_W'(MAX_DIM);
      end
   end

   // Stage 2: Q1.15 by Q1.15 product.
   assign q_use = s1_qok_ff ? q_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_req_ff  <= s1_req_ff;
         s2_last_ff <= s1_last_ff;
         prod_ff    <= q_use * s1_req_ff.element_value;
      end
   end

   // Stage 3: accumulate with saturation at 40 bits, score saturates at 32.
   assign sum = {acc_ff[ACC_W-1], acc_ff}
              + {{(ACC_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = sum[ACC_W-1:0];
      end
      if (acc_sat[ACC_W-1:SCORE_W-1] == '0 || acc_sat[ACC_W-1:SCORE_W-1] == '1) begin
         score_sat = acc_sat[SCORE_W-1:0];
      end else if (acc_sat[ACC_W-1]) begin
         score_sat = {1'b1, {(SCORE_W-1){1'b0}}};
      end else begin
         score_sat = {1'b0, {(SCORE_W-1){1'b1}}};
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff && s2_req_ff.action == ACT_CAND) begin
         acc_in = s2_last_ff ? '0 : acc_sat;
      end
      s3_in.valid  = s2_valid_ff;
      s3_in.action = s2_req_ff.action;
      s3_in.last   = s2_last_ff;
      s3_in.score  = score_sat;
      s3_in.id     = s2_req_ff.candidate_id;
      s3_in.excl   = s2_req_ff.exclude;
      s3_in.rank   = s2_req_ff.rank;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         s3_ff  <= '0;
      end else if (en) begin
         acc_ff <= acc_in;
         s3_ff  <= s3_in;
      end
   end

   assign stage = s3_ff;

endmodule
`default_nettype wire

// ===== rtl/top_n_dot_product_search.sv =====
// Top level: configuration registers, chain of list cells and result register.
//
// Usage: load the normalized query one element per item (action load), then
// stream each candidate one element per item (action candidate); on the element
// that completes vector_length, the candidate's saturated score is inserted into
// a descending list of TOP_N entries unless excluded or below min_score. The
// clear action empties the list; the read action returns one item on the rsp
// channel with the score, id and occupancy of the requested rank.
// Timing: one item is accepted per cycle while the pipeline is not stalled. A read's
// result is registered behind the query memory read, the multiplier and the
// accumulator stages; a candidate's list insert lands on the edge that registers it.
// Items keep their order, so a read sees every earlier insert and clear.
// When the receiver stalls, the result register holds its item and the whole
// pipeline, including req_ready, holds until it is taken.
// Reset clears the list, the accumulator, the element count and the pipeline,
// sets min_score to 0 and vector_length to 256; query contents must be loaded.
`default_nettype none
module top_n_dot_product_search (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire tnds_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output tnds_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_we,
   input  wire tnds_pkg::csr_index_type         csr_index,
   input  wire logic [tnds_pkg::CSR_W-1:0]      csr_wdata
);
   import tnds_pkg::*;

   logic [MIN_W-1:0]          min_score_ff;
   logic [LEN_W-1:0]          vector_length_ff;
   logic [LEN_W-1:0]          eff_len;

   logic                      en;
   logic                      accept;
   stage_type                 stage;

   logic                      thr_ok;
   logic                      insert;
   logic                      clear;

   logic signed [SCORE_W-1:0] cell_score [TOP_N];
   logic [ID_BITS-1:0]        cell_id [TOP_N];
   logic                      cell_gt [TOP_N];

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_score_ff     <= '0;
         vector_length_ff <= LEN_W'(MAX_DIM);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_SCORE:     min_score_ff     <= csr_wdata[MIN_W-1:0];
            CSR_VECTOR_LENGTH: vector_length_ff <= csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      if (vector_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (vector_length_ff > LEN_W'(MAX_DIM)) begin
         eff_len = LEN_W'(MAX_DIM);
      end else begin
         eff_len = vector_length_ff;
      end
   end

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign accept    = req_valid && en;

   tnds_dot u_dot (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .accept  (accept),
      .req     (req_data),
      .eff_len (eff_len),
      .stage   (stage)
   );

   // Threshold in Q2.30 is min_score shifted up by 15.
   assign thr_ok = (min_score_ff == '0)
                || (stage.score >= $signed({2'b00, min_score_ff, {MIN_W{1'b0}}}));
   assign insert = stage.valid && stage.action == ACT_CAND && stage.last
                && !stage.excl && thr_ok;
   assign clear  = stage.valid && stage.action == ACT_CLEAR;

   for (genvar i = 0; i < TOP_N; i++) begin : g_cell
      if (i == 0) begin : g_head
         tnds_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .en         (en),
            .clear      (clear),
            .insert     (insert),
            .new_score  (stage.score),
            .new_id     (stage.id),
            .prev_score ('0),
            .prev_id    ('0),
            .prev_gt    (1'b0),
            .score      (cell_score[i]),
            .id         (cell_id[i]),
            .gt         (cell_gt[i])
         );
      end else begin : g_body
         tnds_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .en         (en),
            .clear      (clear),
            .insert     (insert),
            .new_score  (stage.score),
            .new_id     (stage.id),
            .prev_score (cell_score[i-1]),
            .prev_id    (cell_id[i-1]),
            .prev_gt    (cell_gt[i-1]),
            .score      (cell_score[i]),
            .id         (cell_id[i]),
            .gt         (cell_gt[i])
         );
      end
   end

   always_comb begin
      rsp_valid_in = stage.valid && stage.action == ACT_READ;
      if ({1'b0, stage.rank} < (RANK_W+1)'(TOP_N)) begin
         rsp_data_in.score     = cell_score[stage.rank];
         rsp_data_in.word_id   = cell_id[stage.rank];
         rsp_data_in.valid_res = cell_score[stage.rank] != '0;
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
